FILE: hw/rtl/battery_fault_debounce_assert.svh
// Assertion macros for the battery fault debounce block.
// Needs nothing else; included by battery_fault_debounce, which checks its own logic.
`ifndef BATTERY_FAULT_DEBOUNCE_ASSERT_SVH
`define BATTERY_FAULT_DEBOUNCE_ASSERT_SVH

// same-cycle implication
`define BFD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/bfd_pkg.sv
// Package for the battery fault debounce block: word types, register map,
// reset values and the saturating counter helper. No dependencies.
`timescale 1ns / 1ps

package bfd_pkg;

   localparam int CELL_COUNT_DEF = 8;
   localparam int CODE_W         = 8;
   localparam int TICK_W         = 5;
   localparam int MIN_W          = 4;
   localparam int COUNT_W        = 4;
   localparam int TEMPS_W        = 64;
   localparam int ADDR_W         = 5;
   localparam int DATA_W         = 32;
   localparam int REG_IDX_W      = 3;

   localparam logic [REG_IDX_W-1:0] REG_INVALID_CODE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_VOLT_SET     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_SET     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_CLEAR   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_MIN     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COMM_SET     = 3'd5;

   localparam logic [CODE_W-1:0] RST_INVALID_CODE = 8'd255;
   localparam logic [TICK_W-1:0] RST_VOLT_SET     = 5'd10;
   localparam logic [TICK_W-1:0] RST_TEMP_SET     = 5'd25;
   localparam logic [TICK_W-1:0] RST_TEMP_CLEAR   = 5'd10;
   localparam logic [MIN_W-1:0]  RST_TEMP_MIN     = 4'd3;
   localparam logic [TICK_W-1:0] RST_COMM_SET     = 5'd25;

   typedef struct packed {
      logic               volt_read_fault;
      logic               master_seen;
      logic [TEMPS_W-1:0] temp_vector;
   } req_type;

   typedef struct packed {
      logic               volt_alarm;
      logic               temp_alarm;
      logic               comm_alarm;
      logic [COUNT_W-1:0] invalid_count;
   } rsp_type;

   function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] c);
      return (c == {TICK_W{1'b1}}) ? c : c + TICK_W'(1);
   endfunction

endpackage

FILE: hw/rtl/battery_fault_debounce.sv
// Battery fault debounce: top level with input register, alarm qualifiers and result register.
// Uses bfd_pkg and battery_fault_debounce_assert.svh.
//
// One tick word can be taken every clock cycle while the input is not stalled. An accepted
// word sits in the input register, the whole update of the three alarms and their counters
// runs from there, and the result word is then registered into the result register once
// that register is free or being taken. The input stalls only while the result register holds an
// untaken word and the input register is full, i.e. only when rsp_ready is held low.
`timescale 1ns / 1ps
`include "battery_fault_debounce_assert.svh"

module battery_fault_debounce
   import bfd_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [CODE_W-1:0]  invalid_code_ff;
   logic [TICK_W-1:0]  volt_set_ff;
   logic [TICK_W-1:0]  temp_set_ff;
   logic [TICK_W-1:0]  temp_clear_ff;
   logic [MIN_W-1:0]   temp_min_ff;
   logic [TICK_W-1:0]  comm_set_ff;

   logic               in_vld_ff;
   req_type            in_data_ff;
   logic               out_vld_ff;
   rsp_type            out_data_ff;
   rsp_type            out_data_in;

   logic               volt_alarm_ff, volt_alarm_in;
   logic               temp_alarm_ff, temp_alarm_in;
   logic               comm_alarm_ff, comm_alarm_in;
   logic [TICK_W-1:0]  volt_cnt_ff, volt_cnt_in;
   logic [TICK_W-1:0]  temp_cnt_ff, temp_cnt_in;
   logic [TICK_W-1:0]  comm_cnt_ff, comm_cnt_in;

   logic               advance;
   logic               csr_write;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [COUNT_W-1:0] inv_count;
   logic               temp_bad;

   logic               alarms_match;
   logic [3*TICK_W+2:0] alarm_state;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign reg_idx   = paddr[ADDR_W-1:2];

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_code_ff <= RST_INVALID_CODE;
         volt_set_ff     <= RST_VOLT_SET;
         temp_set_ff     <= RST_TEMP_SET;
         temp_clear_ff   <= RST_TEMP_CLEAR;
         temp_min_ff     <= RST_TEMP_MIN;
         comm_set_ff     <= RST_COMM_SET;
      end else if (csr_write) begin
         case (reg_idx)
            REG_INVALID_CODE: invalid_code_ff <= pwdata[CODE_W-1:0];
            REG_VOLT_SET:     volt_set_ff     <= pwdata[TICK_W-1:0];
            REG_TEMP_SET:     temp_set_ff     <= pwdata[TICK_W-1:0];
            REG_TEMP_CLEAR:   temp_clear_ff   <= pwdata[TICK_W-1:0];
            REG_TEMP_MIN:     temp_min_ff     <= pwdata[MIN_W-1:0];
            REG_COMM_SET:     comm_set_ff     <= pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_INVALID_CODE: prdata = DATA_W'(invalid_code_ff);
         REG_VOLT_SET:     prdata = DATA_W'(volt_set_ff);
         REG_TEMP_SET:     prdata = DATA_W'(temp_set_ff);
         REG_TEMP_CLEAR:   prdata = DATA_W'(temp_clear_ff);
         REG_TEMP_MIN:     prdata = DATA_W'(temp_min_ff);
         REG_COMM_SET:     prdata = DATA_W'(comm_set_ff);
         default:          prdata = '0;
      endcase
   end

   // handshake
   assign advance   = in_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // invalid sensor count
   always_comb begin
      inv_count = '0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (in_data_ff.temp_vector[CODE_W*i +: CODE_W] == invalid_code_ff) begin
            inv_count = inv_count + COUNT_W'(1);
         end
      end
   end

   assign temp_bad = (inv_count >= temp_min_ff);

   // alarm qualification
   always_comb begin
      volt_alarm_in = volt_alarm_ff;
      volt_cnt_in   = volt_cnt_ff;
      if (!volt_alarm_ff) begin
         volt_cnt_in = in_data_ff.volt_read_fault ? bump(volt_cnt_ff) : '0;
         if (volt_cnt_in >= volt_set_ff) begin
            volt_cnt_in   = '0;
            volt_alarm_in = 1'b1;
         end
      end else if (!in_data_ff.volt_read_fault) begin
         volt_alarm_in = 1'b0;
      end

      temp_alarm_in = temp_alarm_ff;
      if (!temp_alarm_ff) begin
         temp_cnt_in = temp_bad ? bump(temp_cnt_ff) : '0;
         if (temp_cnt_in >= temp_set_ff) begin
            temp_cnt_in   = '0;
            temp_alarm_in = 1'b1;
         end
      end else begin
         temp_cnt_in = temp_bad ? '0 : bump(temp_cnt_ff);
         if (temp_cnt_in >= temp_clear_ff) begin
            temp_cnt_in   = '0;
            temp_alarm_in = 1'b0;
         end
      end

      comm_alarm_in = comm_alarm_ff;
      comm_cnt_in   = comm_cnt_ff;
      if (!comm_alarm_ff) begin
         comm_cnt_in = in_data_ff.master_seen ? '0 : bump(comm_cnt_ff);
         if (comm_cnt_in >= comm_set_ff) begin
            comm_cnt_in   = '0;
            comm_alarm_in = 1'b1;
         end
      end else if (in_data_ff.master_seen) begin
         comm_alarm_in = 1'b0;
      end

      out_data_in.volt_alarm    = volt_alarm_in;
      out_data_in.temp_alarm    = temp_alarm_in;
      out_data_in.comm_alarm    = comm_alarm_in;
      out_data_in.invalid_count = inv_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_alarm_ff <= 1'b0;
         temp_alarm_ff <= 1'b0;
         comm_alarm_ff <= 1'b0;
         volt_cnt_ff   <= '0;
         temp_cnt_ff   <= '0;
         comm_cnt_ff   <= '0;
      end else if (advance) begin
         volt_alarm_ff <= volt_alarm_in;
         temp_alarm_ff <= temp_alarm_in;
         comm_alarm_ff <= comm_alarm_in;
         volt_cnt_ff   <= volt_cnt_in;
         temp_cnt_ff   <= temp_cnt_in;
         comm_cnt_ff   <= comm_cnt_in;
      end
   end

   assign alarms_match = (out_data_ff.volt_alarm == volt_alarm_ff) &&
                         (out_data_ff.temp_alarm == temp_alarm_ff) &&
                         (out_data_ff.comm_alarm == comm_alarm_ff);
   assign alarm_state  = {volt_alarm_ff, temp_alarm_ff, comm_alarm_ff,
                          volt_cnt_ff, temp_cnt_ff, comm_cnt_ff};

   `BFD_ASSERT_NOW(a_volt_cnt_idle, clock, reset, volt_alarm_ff, ~|volt_cnt_ff, "volt count moved")
   `BFD_ASSERT_NOW(a_comm_cnt_idle, clock, reset, comm_alarm_ff, ~|comm_cnt_ff, "comm count moved")
   `BFD_ASSERT_NOW(a_rsp_matches, clock, reset, out_vld_ff, alarms_match, "result out of step")
   `BFD_ASSERT_NEXT(a_state_hold, clock, reset, !advance, $stable(alarm_state), "state moved idle")
   `BFD_ASSERT_NEXT(a_word_out, clock, reset, advance, out_vld_ff, "processed word not presented")

endmodule

FILE: bench/bfd_alarm_monitor.sv
// Alarm monitor for battery_fault_debounce: follows register writes and tick words,
// predicts the three debounced alarms and the invalid cell count, and compares results.
// Depends on bfd_pkg only.
`timescale 1ns / 1ps

module bfd_alarm_monitor
   import bfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output int                pending,
   output int                fail_count,
   output int                results_checked
);

   logic [CODE_W-1:0] cfg_code;
   logic [TICK_W-1:0] cfg_volt_set;
   logic [TICK_W-1:0] cfg_temp_set;
   logic [TICK_W-1:0] cfg_temp_clear;
   logic [MIN_W-1:0]  cfg_temp_min;
   logic [TICK_W-1:0] cfg_comm_set;

   logic              volt_on, temp_on, comm_on;
   logic [TICK_W-1:0] volt_cnt, temp_cnt, comm_cnt;

   rsp_type alarm_expect_q[$];
   int      miss_n;
   int      checked_n;

   function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   function automatic rsp_type qualify_tick(input req_type t);
      rsp_type            r;
      logic [COUNT_W-1:0] n;
      logic               bad;
      n = '0;
      for (int i = 0; i < CELL_COUNT_DEF; i++) begin
         if (t.temp_vector[8*i +: 8] == cfg_code) n = n + 1'b1;
      end

      if (!volt_on) begin
         volt_cnt = t.volt_read_fault ? sat_inc(volt_cnt) : '0;
         if (volt_cnt >= cfg_volt_set) begin
            volt_cnt = '0;
            volt_on  = 1'b1;
         end
      end else if (!t.volt_read_fault) begin
         volt_on = 1'b0;
      end

      bad = (n >= cfg_temp_min);
      if (!temp_on) begin
         temp_cnt = bad ? sat_inc(temp_cnt) : '0;
         if (temp_cnt >= cfg_temp_set) begin
            temp_cnt = '0;
            temp_on  = 1'b1;
         end
      end else begin
         temp_cnt = bad ? '0 : sat_inc(temp_cnt);
         if (temp_cnt >= cfg_temp_clear) begin
            temp_cnt = '0;
            temp_on  = 1'b0;
         end
      end

      if (!comm_on) begin
         comm_cnt = t.master_seen ? '0 : sat_inc(comm_cnt);
         if (comm_cnt >= cfg_comm_set) begin
            comm_cnt = '0;
            comm_on  = 1'b1;
         end
      end else if (t.master_seen) begin
         comm_on = 1'b0;
      end

      r.volt_alarm    = volt_on;
      r.temp_alarm    = temp_on;
      r.comm_alarm    = comm_on;
      r.invalid_count = n;
      return r;
   endfunction

   task automatic store_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
      case (idx)
         REG_INVALID_CODE: cfg_code       = d[CODE_W-1:0];
         REG_VOLT_SET:     cfg_volt_set   = d[TICK_W-1:0];
         REG_TEMP_SET:     cfg_temp_set   = d[TICK_W-1:0];
         REG_TEMP_CLEAR:   cfg_temp_clear = d[TICK_W-1:0];
         REG_TEMP_MIN:     cfg_temp_min   = d[MIN_W-1:0];
         REG_COMM_SET:     cfg_comm_set   = d[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic flag_miss(input string msg);
      miss_n++;
      if (miss_n <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string field, input logic [3:0] want,
                                input logic [3:0] got);
      if (got !== want) flag_miss($sformatf("%s expected %0d actual %0d", field, want, got));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_code       = RST_INVALID_CODE;
         cfg_volt_set   = RST_VOLT_SET;
         cfg_temp_set   = RST_TEMP_SET;
         cfg_temp_clear = RST_TEMP_CLEAR;
         cfg_temp_min   = RST_TEMP_MIN;
         cfg_comm_set   = RST_COMM_SET;
         volt_on        = 1'b0;
         temp_on        = 1'b0;
         comm_on        = 1'b0;
         volt_cnt       = '0;
         temp_cnt       = '0;
         comm_cnt       = '0;
         alarm_expect_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) store_reg(paddr[ADDR_W-1:2], pwdata);
         if (req_valid && req_ready) alarm_expect_q.push_back(qualify_tick(req_data));
         if (rsp_valid && rsp_ready) begin
            if (alarm_expect_q.size() == 0) begin
               flag_miss($sformatf("unexpected result word %h", rsp_word));
            end else begin
               want = alarm_expect_q.pop_front();
               compare_field("volt_alarm", 4'(want.volt_alarm), 4'(rsp_word.volt_alarm));
               compare_field("temp_alarm", 4'(want.temp_alarm), 4'(rsp_word.temp_alarm));
               compare_field("comm_alarm", 4'(want.comm_alarm), 4'(rsp_word.comm_alarm));
               compare_field("invalid_count", want.invalid_count, rsp_word.invalid_count);
               checked_n++;
            end
         end
      end
      pending         <= alarm_expect_q.size();
      fail_count      <= miss_n;
      results_checked <= checked_n;
   end

endmodule

FILE: bench/battery_fault_debounce_tb.sv
// Testbench top for battery_fault_debounce: clock, reset, register phases and tick words
// with random idling on both channels; the verdict comes from bfd_alarm_monitor.
// Depends on bfd_pkg, bfd_alarm_monitor and the block itself.
`timescale 1ns / 1ps

module battery_fault_debounce_tb;
   import bfd_pkg::*;

   localparam int PHASES      = 16;
   localparam int PHASE_TICKS = 108;
   localparam int HOLD_CYCLES = 60;
   localparam int LIMIT       = 400000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_word;
   logic              psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int pending, fail_count, results_checked;
   int cycle_cnt = 0;
   int ticks_sent;
   bit calm;
   bit long_hold, long_hold_done;

   logic [CODE_W-1:0] tb_code;
   logic [MIN_W-1:0]  tb_min;
   int  volt_left, seen_left, temp_left;
   bit  volt_flag, seen_flag, temp_bad;

   battery_fault_debounce dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bfd_alarm_monitor alarm_mon (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .pending(pending), .fail_count(fail_count), .results_checked(results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold on request
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready      <= 1'b1;
            long_hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_tick(input req_type t);
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic maybe_gap();
      int n;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 6);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic csr_write(input int idx, input logic [DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx * 4);
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == int'(REG_INVALID_CODE)) tb_code = val[CODE_W-1:0];
      if (idx == int'(REG_TEMP_MIN)) tb_min = val[MIN_W-1:0];
   endtask

   // block must be drained before register writes
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int run_len();
      return ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 40);
   endfunction

   function automatic logic [DATA_W-1:0] pick_ticks();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'd31;
         2:       return $urandom_range(1, 31);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_min();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'd15;
         2:       return 32'd8;
         3:       return 32'd9;
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_code();
      case ($urandom_range(0, 3))
         0:       return 32'd0;
         1:       return 32'd255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // junk above the register width
   function automatic logic [DATA_W-1:0] junk(input logic [DATA_W-1:0] v, input int w);
      return ($urandom_range(0, 3) == 0) ? (v | ($urandom << w)) : v;
   endfunction

   task automatic make_tick(output req_type t);
      int         k;
      logic [7:0] hits;
      if (volt_left == 0) begin
         volt_flag = 1'($urandom_range(0, 1));
         volt_left = run_len();
      end
      volt_left--;
      if (seen_left == 0) begin
         seen_flag = ($urandom_range(0, 2) == 0);
         seen_left = seen_flag ? $urandom_range(1, 4) : run_len();
      end
      seen_left--;
      if (temp_left == 0) begin
         temp_bad  = 1'($urandom_range(0, 1));
         temp_left = run_len();
      end
      temp_left--;

      t.volt_read_fault = volt_flag;
      t.master_seen     = seen_flag;
      t.temp_vector     = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
         t.volt_read_fault = 1'($urandom_range(0, 1));
         t.master_seen     = 1'($urandom_range(0, 1));
      end else begin
         for (int i = 0; i < 8; i++) begin
            if (t.temp_vector[8*i +: 8] == tb_code) t.temp_vector[8*i] = ~t.temp_vector[8*i];
         end
         if (tb_min == 0 || tb_min > 8) k = $urandom_range(0, 8);
         else if (temp_bad) k = $urandom_range(tb_min, 8);
         else k = $urandom_range(0, tb_min - 1);
         hits = '0;
         while ($countones(hits) < k) hits[3'($urandom_range(0, 7))] = 1'b1;
         for (int i = 0; i < 8; i++) begin
            if (hits[i]) t.temp_vector[8*i +: 8] = tb_code;
         end
      end
   endtask

   initial begin
      req_type t;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      calm           = 1'b0;
      long_hold      = 1'b0;
      ticks_sent     = 0;
      tb_code        = RST_INVALID_CODE;
      tb_min         = RST_TEMP_MIN;
      volt_left      = 0;
      seen_left      = 0;
      temp_left      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed words under reset settings
      for (int i = 0; i < 12; i++) begin
         t.volt_read_fault = i[0];
         t.master_seen     = i[1];
         case (i)
            0:       t.temp_vector = '0;
            1:       t.temp_vector = '1;
            2:       t.temp_vector = 64'hFEFE_FEFE_FEFE_FEFE;
            3:       t.temp_vector = 64'h7F7F_7F7F_7F7F_7F7F;
            default: t.temp_vector = ({64{1'b1}} >> (8 * (i - 3))) | 64'h0101_0101_0101_0100;
         endcase
         if (i >= 4) t.temp_vector = {64{1'b1}} << (8 * (i - 3));
         send_tick(t);
      end
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               csr_write(int'(REG_INVALID_CODE), 32'd0);
               csr_write(int'(REG_VOLT_SET), 32'd0);
               csr_write(int'(REG_TEMP_SET), 32'd0);
               csr_write(int'(REG_TEMP_CLEAR), 32'd0);
               csr_write(int'(REG_TEMP_MIN), 32'd0);
               csr_write(int'(REG_COMM_SET), 32'd0);
               csr_write(6, 32'hFFFF_FFFF);
               csr_write(7, 32'h0000_0001);
            end
            1: begin
               csr_write(int'(REG_INVALID_CODE), 32'hFFFF_FFFF);
               csr_write(int'(REG_VOLT_SET), 32'd31);
               csr_write(int'(REG_TEMP_SET), 32'd31);
               csr_write(int'(REG_TEMP_CLEAR), 32'd31);
               csr_write(int'(REG_TEMP_MIN), 32'd15);
               csr_write(int'(REG_COMM_SET), 32'd31);
            end
            2: begin
               csr_write(int'(REG_INVALID_CODE), 32'h5A);
               csr_write(int'(REG_VOLT_SET), 32'd1);
               csr_write(int'(REG_TEMP_SET), 32'd1);
               csr_write(int'(REG_TEMP_CLEAR), 32'd1);
               csr_write(int'(REG_TEMP_MIN), 32'd8);
               csr_write(int'(REG_COMM_SET), 32'd1);
            end
            default: begin
               csr_write(int'(REG_INVALID_CODE), junk(pick_code(), CODE_W));
               csr_write(int'(REG_VOLT_SET), junk(pick_ticks(), TICK_W));
               csr_write(int'(REG_TEMP_SET), junk(pick_ticks(), TICK_W));
               csr_write(int'(REG_TEMP_CLEAR), junk(pick_ticks(), TICK_W));
               csr_write(int'(REG_TEMP_MIN), junk(pick_min(), MIN_W));
               csr_write(int'(REG_COMM_SET), junk(pick_ticks(), TICK_W));
               if ($urandom_range(0, 3) == 0) csr_write($urandom_range(6, 7), $urandom);
            end
         endcase
         if (ph >= PHASES - 2) calm = 1'b1;
         for (int n = 0; n < PHASE_TICKS; n++) begin
            if (ph == 4 && n == 10) long_hold = 1'b1;
            maybe_gap();
            make_tick(t);
            send_tick(t);
         end
         drain();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d tick words across %0d register settings (zero, max and random).",
               ticks_sent, PHASES + 1);
      $display("Compared %0d result words; %0d mismatches.", results_checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bfd_pkg.sv
hw/rtl/battery_fault_debounce.sv
bench/bfd_alarm_monitor.sv
bench/battery_fault_debounce_tb.sv
